// ----- sv/lrz_pkg.sv -----
// ----------------------------------------------------------------------------
// lrz_pkg: shared types and constants for the line rasterizer
// Coordinate width, beat layouts, operation and minor step codes.
// ----------------------------------------------------------------------------
package lrz_pkg;

  // coordinate width and derived widths
  localparam int COORD_BITS = 10;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int INC_W      = COORD_BITS + 2;
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [INC_W-1:0] inc_t;

  // operation carried in the input tuser
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // direction of the minor coordinate step
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // one input beat, unpacked
  typedef struct packed {
    op_t    op;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } item_t;

  // one result beat
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    logic   last_pixel;
  } result_t;

  // walk status seen by the top level
  typedef struct packed {
    logic busy;
    logic fire;
  } status_t;

endpackage

// ----- sv/lrz_in_stage.sv -----
// ----------------------------------------------------------------------------
// lrz_in_stage: input register of the line rasterizer
// Takes slave beats into one register and unpacks the fields.
// ----------------------------------------------------------------------------
module lrz_in_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lrz_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tuser,
  output lrz_pkg::item_t                  item,
  output logic                            item_valid,
  input  logic                            item_ready
);
  import lrz_pkg::*;

  logic  vld;
  item_t data;

  // room when empty or when the held beat moves on this cycle
  assign s_axis_tready = !vld || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_axis_tready) begin
      vld <= s_axis_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data.op      <= op_t'(s_axis_tuser);
      data.x_start <= s_axis_tdata[COORD_BITS-1:0];
      data.y_start <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      data.x_end   <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
      data.y_end   <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    end
  end

  assign item       = data;
  assign item_valid = vld;

endmodule

// ----- sv/lrz_core.sv -----
// ----------------------------------------------------------------------------
// lrz_core: Bresenham walk state and step logic
// Sets up a segment on start, steps one pixel per advance beat.
// ----------------------------------------------------------------------------
module lrz_core (
  input  logic              clk,
  input  logic              rst,
  input  lrz_pkg::item_t    item,
  input  logic              item_valid,
  output logic              item_ready,
  output lrz_pkg::result_t  res,
  output logic              res_valid,
  input  logic              res_ready,
  output lrz_pkg::status_t  status
);
  import lrz_pkg::*;

  // walk state
  coord_t cur_x, cur_y, major_end;
  err_t   error_term;
  inc_t   inc_no_step;
  err_t   inc_step;
  logic   x_is_major;
  dir_t   minor_dir;
  logic   busy;

  coord_t cur_x_next, cur_y_next, major_end_next;
  err_t   error_term_next;
  inc_t   inc_no_step_next;
  err_t   inc_step_next;
  logic   x_is_major_next;
  dir_t   minor_dir_next;
  logic   busy_next;
  result_t res_c;
  logic   fire;

  assign item_ready = res_ready;
  assign res_valid  = item_valid;
  assign fire       = item_valid && res_ready;

  // next state and result for the beat at the head
  always_comb begin
    coord_t dx, dy, sx, sy, ex, ey, smaj, emaj, smin, emin, dmaj, dmin;
    coord_t maj, mnr;
    logic   xm, swap;

    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    major_end_next   = major_end;
    error_term_next  = error_term;
    inc_no_step_next = inc_no_step;
    inc_step_next    = inc_step;
    x_is_major_next  = x_is_major;
    minor_dir_next   = minor_dir;
    busy_next        = busy;
    res_c            = '0;

    // segment setup
    dx   = (item.x_start > item.x_end) ? item.x_start - item.x_end
                                       : item.x_end - item.x_start;
    dy   = (item.y_start > item.y_end) ? item.y_start - item.y_end
                                       : item.y_end - item.y_start;
    xm   = dx > dy;
    swap = xm ? (item.x_start > item.x_end) : (item.y_start > item.y_end);
    sx   = swap ? item.x_end : item.x_start;
    sy   = swap ? item.y_end : item.y_start;
    ex   = swap ? item.x_start : item.x_end;
    ey   = swap ? item.y_start : item.y_end;
    smaj = xm ? sx : sy;
    emaj = xm ? ex : ey;
    smin = xm ? sy : sx;
    emin = xm ? ey : ex;
    dmaj = xm ? dx : dy;
    dmin = xm ? dy : dx;

    // one step of the current walk
    maj = x_is_major ? cur_x : cur_y;
    mnr = x_is_major ? cur_y : cur_x;
    maj = maj + coord_t'(1);

    case (item.op)
      OP_START: begin
        cur_x_next       = sx;
        cur_y_next       = sy;
        major_end_next   = emaj;
        x_is_major_next  = xm;
        minor_dir_next   = (emin > smin) ? DIR_UP : ((emin < smin) ? DIR_DOWN : DIR_NONE);
        error_term_next  = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
        inc_no_step_next = {1'b0, dmin, 1'b0};
        inc_step_next    = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
        busy_next        = smaj != emaj;
        res_c.pixel_x     = sx;
        res_c.pixel_y     = sy;
        res_c.pixel_valid = 1'b1;
        res_c.last_pixel  = smaj == emaj;
      end
      OP_ADVANCE: begin
        if (busy) begin
          if (error_term[ERR_W-1]) begin
            error_term_next = error_term + $signed({1'b0, inc_no_step});
          end else begin
            case (minor_dir)
              DIR_UP:   mnr = mnr + coord_t'(1);
              DIR_DOWN: mnr = mnr - coord_t'(1);
              default:  mnr = mnr;
            endcase
            error_term_next = error_term + inc_step;
          end
          cur_x_next        = x_is_major ? maj : mnr;
          cur_y_next        = x_is_major ? mnr : maj;
          busy_next         = maj != major_end;
          res_c.pixel_x     = cur_x_next;
          res_c.pixel_y     = cur_y_next;
          res_c.pixel_valid = 1'b1;
          res_c.last_pixel  = maj == major_end;
        end
      end
      default: begin
        res_c = '0;
      end
    endcase
  end

  // state update on each beat that moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      major_end   <= '0;
      error_term  <= '0;
      inc_no_step <= '0;
      inc_step    <= '0;
      x_is_major  <= 1'b0;
      minor_dir   <= DIR_NONE;
      busy        <= 1'b0;
    end else if (fire) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      major_end   <= major_end_next;
      error_term  <= error_term_next;
      inc_no_step <= inc_no_step_next;
      inc_step    <= inc_step_next;
      x_is_major  <= x_is_major_next;
      minor_dir   <= minor_dir_next;
      busy        <= busy_next;
    end
  end

  assign res         = res_c;
  assign status.busy = busy;
  assign status.fire = fire;

endmodule

// ----- sv/lrz_out_stage.sv -----
// ----------------------------------------------------------------------------
// lrz_out_stage: result register of the line rasterizer
// Holds one result beat and packs it onto the master side.
// ----------------------------------------------------------------------------
module lrz_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  lrz_pkg::result_t                res,
  input  logic                            res_valid,
  output logic                            res_ready,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lrz_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import lrz_pkg::*;

  logic    vld;
  result_t data;

  // room when empty or when the held beat is taken this cycle
  assign res_ready = !vld || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (res_ready) begin
      vld <= res_valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data <= res;
    end
  end

  // pack coordinates, zero fill to whole bytes
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[COORD_BITS-1:0]            = data.pixel_x;
    m_axis_tdata[2*COORD_BITS-1:COORD_BITS] = data.pixel_y;
  end

  assign m_axis_tvalid = vld;
  assign m_axis_tuser  = data.pixel_valid;
  assign m_axis_tlast  = data.last_pixel;

endmodule

// ----- sv/bresenham_line_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit: integer Bresenham line walker
// Turns start and advance beats into one pixel beat each.
// ----------------------------------------------------------------------------
// Usage
//   Slave side: tuser is the operation (0 start, 1 advance); tdata carries
//   x_start, y_start, x_end, y_end from the low bits up (read on start only).
//   A start beat sets up a segment and returns its first pixel; each advance
//   beat returns the next pixel. tlast marks the final pixel of the segment.
//   An advance with no segment in progress returns a beat with tuser low and
//   zero coordinates. A start during a walk drops the old segment.
//   Master side: tdata holds pixel_x, pixel_y from the low bits up; tuser is
//   pixel_valid; tlast is last_pixel.
//   Path: the input register takes the beat, the step logic works on it,
//   and the result register holds the result for the master side.
//   Throughput: one beat per cycle while the receiver takes results; the
//   walk state updates with an add and a compare per pixel, so beats can
//   follow back to back. Reset clears the walk state and the valid flags
//   of both stage registers; the block is idle. When the receiver stalls
//   the result register holds, the input register fills, and tready drops
//   only once both are full.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // x_start, y_start, x_end, y_end
  input  logic [lrz_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_x, pixel_y, zero fill
  output logic [lrz_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // pixel_valid
  output logic                            m_axis_tuser,
  // last_pixel
  output logic                            m_axis_tlast
);
  import lrz_pkg::*;

  item_t   item;
  logic    item_valid, item_ready;
  result_t res;
  logic    res_valid, res_ready;
  status_t status;

  // input register
  lrz_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item          (item),
    .item_valid    (item_valid),
    .item_ready    (item_ready)
  );

  // walk state and step logic
  lrz_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .status     (status)
  );

  // result register
  lrz_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a last marker only ever comes with a real pixel
  a_last_is_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last beat without a valid pixel");

  // an idle advance reports zero coordinates
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("idle beat with nonzero coordinates");

  // a pixel that is not the last leaves the walk running
  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    status.fire && res.pixel_valid && !res.last_pixel |=> status.busy)
    else $error("walk stopped before its last pixel");

  // a held input beat is not lost while the result side is stalled
  a_in_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid)
    else $error("input beat dropped under stall");

endmodule
